@@ sv/qou_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qou_pkg
// Shared types, constants and helper functions of the orientation unit.
// ----------------------------------------------------------------------------
package qou_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;

   // datapath widths
   localparam int VAL_W  = 34;                 // q30 values with headroom
   localparam int PROD_W = 2 * VAL_W;
   localparam int N2_W   = 64;
   localparam int LEN_W  = 33;
   localparam int REM_W  = LEN_W + 1;
   localparam int DIV_W  = VAL_W + FRAC_BITS;  // numerator and quotient width
   localparam int SQRT_STEPS = N2_W / 2;
   localparam int CNT_W  = $clog2(DIV_W);
   localparam int STEP_W = 4;

   localparam int HT_SHL = (ANGLE_BITS <= 31) ? (31 - ANGLE_BITS) : 0;
   localparam int HT_SHR = (ANGLE_BITS > 31) ? (ANGLE_BITS - 31) : 0;

   localparam logic signed [VAL_W-1:0]  KINV_Q30  = VAL_W'(652032874);
   localparam logic signed [PROD_W-1:0] HALF_Q30  = PROD_W'(536870912);
   localparam logic signed [15:0]       ONE_FIXED =
      (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);

   // mode and axis codes
   localparam logic [1:0] MODE_EULER  = 2'd0;
   localparam logic [1:0] MODE_LOCAL  = 2'd1;
   localparam logic [1:0] MODE_WORLD  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] AXIS_X      = 2'd0;
   localparam logic [1:0] AXIS_Y      = 2'd1;
   localparam logic [1:0] AXIS_Z      = 2'd2;
   localparam logic [1:0] AXIS_NONE   = 2'd3;

   // angle source slots of the sine/cosine unit
   localparam logic [1:0] SRC_ROLL  = 2'd0;
   localparam logic [1:0] SRC_PITCH = 2'd1;
   localparam logic [1:0] SRC_YAW   = 2'd2;
   localparam logic [1:0] SRC_ANGLE = 2'd3;

   // datapath commands
   localparam logic [4:0] OP_NOP       = 5'd0;
   localparam logic [4:0] OP_LOAD      = 5'd1;
   localparam logic [4:0] OP_KEEP      = 5'd2;
   localparam logic [4:0] OP_CS_INIT   = 5'd3;
   localparam logic [4:0] OP_CS_STEP   = 5'd4;
   localparam logic [4:0] OP_CS_STORE  = 5'd5;
   localparam logic [4:0] OP_EUL_MUL   = 5'd6;
   localparam logic [4:0] OP_EUL_ACC   = 5'd7;
   localparam logic [4:0] OP_SQRT_INIT = 5'd8;
   localparam logic [4:0] OP_SQRT_STEP = 5'd9;
   localparam logic [4:0] OP_IDENT     = 5'd10;
   localparam logic [4:0] OP_DIV_INIT  = 5'd11;
   localparam logic [4:0] OP_DIV_STEP  = 5'd12;
   localparam logic [4:0] OP_DIV_STORE = 5'd13;
   localparam logic [4:0] OP_ROT_MUL   = 5'd14;
   localparam logic [4:0] OP_ROT_ACC   = 5'd15;
   localparam logic [4:0] OP_ROT_RND   = 5'd16;
   localparam logic [4:0] OP_COMMIT    = 5'd17;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         axis;
      logic signed [15:0] angle;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_w;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic [4:0]       op;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       axis_bad;
      logic       len_zero;
      logic       out_busy;
   } sts_type;

   // rounded arctangent table, 2^32 is a full turn
   function automatic logic [29:0] atan_turn(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // binary angle to half angle on a 32-bit full turn
   function automatic logic [31:0] half_turn(input logic signed [15:0] a);
      logic [63:0] e;
      e = 64'(a);
      e = e << HT_SHL;
      e = e >> HT_SHR;
      return e[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
      logic signed [15:0] r;
      if (v > PROD_W'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -PROD_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // sign of the term p[j] * q[k ^ j] in component k of a hamilton product
   function automatic logic ham_neg(input logic [1:0] k, input logic [1:0] j);
      logic n;
      case (k)
         2'd0:    n = (j != 2'd0);
         2'd1:    n = (j == 2'd3);
         2'd2:    n = (j == 2'd1);
         default: n = (j == 2'd2);
      endcase
      return n;
   endfunction

endpackage

@@ sv/qou_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qou_ctrl
// Sequencer of the orientation unit: steps the datapath through sine/cosine,
// product sums, square root, division or the hamilton product.
// ----------------------------------------------------------------------------
module qou_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qou_pkg::sts_type sts,
   output qou_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DISPATCH  = 5'd1;
   localparam logic [4:0] S_CS_INIT   = 5'd2;
   localparam logic [4:0] S_CS_STEP   = 5'd3;
   localparam logic [4:0] S_CS_STORE  = 5'd4;
   localparam logic [4:0] S_EUL_MUL   = 5'd5;
   localparam logic [4:0] S_EUL_ACC   = 5'd6;
   localparam logic [4:0] S_SQRT_INIT = 5'd7;
   localparam logic [4:0] S_SQRT_STEP = 5'd8;
   localparam logic [4:0] S_SQRT_CHK  = 5'd9;
   localparam logic [4:0] S_DIV_INIT  = 5'd10;
   localparam logic [4:0] S_DIV_STEP  = 5'd11;
   localparam logic [4:0] S_DIV_STORE = 5'd12;
   localparam logic [4:0] S_ROT_MUL   = 5'd13;
   localparam logic [4:0] S_ROT_ACC   = 5'd14;
   localparam logic [4:0] S_ROT_RND   = 5'd15;
   localparam logic [4:0] S_DONE      = 5'd16;

   logic [4:0]                   state_ff, state_in;
   logic [qou_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [qou_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [1:0]                   src_ff, src_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      src_in    = src_ff;
      cmd.op    = qou_pkg::OP_NOP;
      cmd.idx   = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = qou_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.mode == qou_pkg::MODE_EULER) begin
               src_in   = qou_pkg::SRC_ROLL;
               state_in = S_CS_INIT;
            end else if ((sts.mode == qou_pkg::MODE_LOCAL ||
                          sts.mode == qou_pkg::MODE_WORLD) && !sts.axis_bad) begin
               src_in   = qou_pkg::SRC_ANGLE;
               state_in = S_CS_INIT;
            end else begin
               cmd.op   = qou_pkg::OP_KEEP;
               state_in = S_DONE;
            end
         end
         S_CS_INIT: begin
            cmd.op   = qou_pkg::OP_CS_INIT;
            cmd.idx  = qou_pkg::CNT_W'(src_ff);
            cnt_in   = '0;
            state_in = S_CS_STEP;
         end
         S_CS_STEP: begin
            cmd.op  = qou_pkg::OP_CS_STEP;
            cmd.idx = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == qou_pkg::CNT_W'(qou_pkg::CORDIC_STEPS - 1)) begin
               state_in = S_CS_STORE;
            end
         end
         S_CS_STORE: begin
            cmd.op  = qou_pkg::OP_CS_STORE;
            cmd.idx = qou_pkg::CNT_W'(src_ff);
            step_in = '0;
            if (src_ff == qou_pkg::SRC_ANGLE) begin
               state_in = S_ROT_MUL;
            end else if (src_ff == qou_pkg::SRC_YAW) begin
               state_in = S_EUL_MUL;
            end else begin
               src_in   = src_ff + 1'b1;
               state_in = S_CS_INIT;
            end
         end
         S_EUL_MUL: begin
            cmd.op   = qou_pkg::OP_EUL_MUL;
            cmd.idx  = qou_pkg::CNT_W'(step_ff);
            state_in = S_EUL_ACC;
         end
         S_EUL_ACC: begin
            cmd.op  = qou_pkg::OP_EUL_ACC;
            cmd.idx = qou_pkg::CNT_W'(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_SQRT_INIT;
            end else begin
               state_in = S_EUL_MUL;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = qou_pkg::OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT_STEP;
         end
         S_SQRT_STEP: begin
            cmd.op = qou_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == qou_pkg::CNT_W'(qou_pkg::SQRT_STEPS - 1)) begin
               state_in = S_SQRT_CHK;
            end
         end
         S_SQRT_CHK: begin
            step_in = '0;
            if (sts.len_zero) begin
               cmd.op   = qou_pkg::OP_IDENT;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.op   = qou_pkg::OP_DIV_INIT;
            cmd.idx  = qou_pkg::CNT_W'(step_ff);
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = qou_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == qou_pkg::CNT_W'(qou_pkg::DIV_W - 1)) begin
               state_in = S_DIV_STORE;
            end
         end
         S_DIV_STORE: begin
            cmd.op  = qou_pkg::OP_DIV_STORE;
            cmd.idx = qou_pkg::CNT_W'(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == qou_pkg::STEP_W'(3)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV_INIT;
            end
         end
         S_ROT_MUL: begin
            cmd.op   = qou_pkg::OP_ROT_MUL;
            cmd.idx  = qou_pkg::CNT_W'(step_ff);
            state_in = S_ROT_ACC;
         end
         S_ROT_ACC: begin
            cmd.op  = qou_pkg::OP_ROT_ACC;
            cmd.idx = qou_pkg::CNT_W'(step_ff);
            if (step_ff[1:0] == 2'd3) begin
               state_in = S_ROT_RND;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_ROT_MUL;
            end
         end
         S_ROT_RND: begin
            cmd.op  = qou_pkg::OP_ROT_RND;
            cmd.idx = qou_pkg::CNT_W'(step_ff);
            if (step_ff == '1) begin
               state_in = S_DONE;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_ROT_MUL;
            end
         end
         S_DONE: begin
            // wait until the output register is free
            if (!sts.out_busy) begin
               cmd.op   = qou_pkg::OP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         step_ff  <= '0;
         src_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         src_ff   <= src_in;
      end
   end

endmodule

@@ sv/qou_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qou_dpath
// Datapath of the orientation unit: cordic, shared multiplier, square root,
// restoring divider, stored quaternion and output register.
// ----------------------------------------------------------------------------
module qou_dpath (
   input  logic             clock,
   input  logic             reset,
   input  qou_pkg::req_type req_data,
   input  qou_pkg::cmd_type cmd,
   output qou_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qou_pkg::rsp_type rsp_data
);

   localparam int VW = qou_pkg::VAL_W;
   localparam int PW = qou_pkg::PROD_W;
   localparam int DW = qou_pkg::DIV_W;
   localparam int LEN_W_L = qou_pkg::LEN_W;

   qou_pkg::req_type           item_ff;
   logic signed [15:0]         orient_ff [4];
   logic signed [15:0]         res_ff [4];
   logic signed [VW-1:0]       cx_ff, cy_ff, cz_ff;
   logic                       flip_ff;
   logic signed [VW-1:0]       c_ff [4];
   logic signed [VW-1:0]       s_ff [4];
   logic signed [VW-1:0]       t_ff [4];
   logic signed [VW-1:0]       q_ff [4];
   logic signed [PW-1:0]       prod_ff;
   logic signed [PW-1:0]       acc_ff;
   logic [qou_pkg::N2_W-1:0]   n2_ff, sq_n_ff, sq_r_ff, sq_bit_ff;
   logic [DW-1:0]              num_ff, quo_ff;
   logic [qou_pkg::REM_W-1:0]  rem_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff;
   qou_pkg::rsp_type           rsp_ff;

   logic [1:0]                 k_sel, j_sel, m_sel;
   logic [4:0]                 ci;
   logic signed [VW-1:0]       mul_a, mul_b;
   logic signed [VW-1:0]       rvec [4];
   logic signed [VW-1:0]       ovec [4];
   logic signed [PW-1:0]       rnd_full, rot_full, term;
   logic signed [VW-1:0]       r30;
   logic [LEN_W_L-1:0]         len;
   logic [31:0]                ht;
   logic [31:0]                ht_adj;
   logic                       ht_flip;
   logic signed [15:0]         src_angle;
   logic [qou_pkg::N2_W-1:0]   sq_t;
   logic [qou_pkg::REM_W-1:0]  rem_sh;
   logic [VW-1:0]              mag;
   logic signed [VW-1:0]       zinc;
   logic signed [VW-1:0]       c_st, s_st;

   assign k_sel = cmd.idx[3:2];
   assign j_sel = cmd.idx[1:0];
   assign m_sel = k_sel ^ j_sel;
   assign ci    = cmd.idx[4:0];
   assign len   = sq_r_ff[LEN_W_L-1:0];

   // rotation quaternion and stored quaternion as multiplier operands
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ovec[i] = VW'(orient_ff[i]);
         rvec[i] = '0;
      end
      rvec[0] = c_ff[qou_pkg::SRC_ANGLE];
      case (item_ff.axis)
         qou_pkg::AXIS_X: rvec[1] = s_ff[qou_pkg::SRC_ANGLE];
         qou_pkg::AXIS_Y: rvec[2] = s_ff[qou_pkg::SRC_ANGLE];
         qou_pkg::AXIS_Z: rvec[3] = s_ff[qou_pkg::SRC_ANGLE];
         default:         rvec[0] = c_ff[qou_pkg::SRC_ANGLE];
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         qou_pkg::OP_EUL_MUL: begin
            case (cmd.idx[3:0])
               4'd0:  begin mul_a = c_ff[0]; mul_b = c_ff[1]; end
               4'd1:  begin mul_a = s_ff[0]; mul_b = s_ff[1]; end
               4'd2:  begin mul_a = s_ff[0]; mul_b = c_ff[1]; end
               4'd3:  begin mul_a = c_ff[0]; mul_b = s_ff[1]; end
               4'd4:  begin mul_a = t_ff[0]; mul_b = c_ff[2]; end
               4'd5:  begin mul_a = t_ff[1]; mul_b = s_ff[2]; end
               4'd6:  begin mul_a = t_ff[2]; mul_b = c_ff[2]; end
               4'd7:  begin mul_a = t_ff[3]; mul_b = s_ff[2]; end
               4'd8:  begin mul_a = t_ff[3]; mul_b = c_ff[2]; end
               4'd9:  begin mul_a = t_ff[2]; mul_b = s_ff[2]; end
               4'd10: begin mul_a = t_ff[0]; mul_b = s_ff[2]; end
               4'd11: begin mul_a = t_ff[1]; mul_b = c_ff[2]; end
               default: begin
                  // squares for the length
                  mul_a = q_ff[cmd.idx[1:0]];
                  mul_b = q_ff[cmd.idx[1:0]];
               end
            endcase
         end
         qou_pkg::OP_ROT_MUL: begin
            if (item_ff.mode == qou_pkg::MODE_WORLD) begin
               mul_a = rvec[j_sel];
               mul_b = ovec[m_sel];
            end else begin
               mul_a = ovec[j_sel];
               mul_b = rvec[m_sel];
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rnd_full = (prod_ff + qou_pkg::HALF_Q30) >>> 30;
      r30      = rnd_full[VW-1:0];
      rot_full = (acc_ff + qou_pkg::HALF_Q30) >>> 30;
      term     = qou_pkg::ham_neg(k_sel, j_sel) ? -prod_ff : prod_ff;
      case (cmd.idx[1:0])
         qou_pkg::SRC_ROLL:  src_angle = item_ff.roll;
         qou_pkg::SRC_PITCH: src_angle = item_ff.pitch;
         qou_pkg::SRC_YAW:   src_angle = item_ff.yaw;
         default:            src_angle = item_ff.angle;
      endcase
      ht      = qou_pkg::half_turn(src_angle);
      ht_flip = (ht[31:30] == 2'b01) || (ht[31:30] == 2'b10);
      ht_adj  = ht_flip ? (ht + 32'h8000_0000) : ht;
      zinc    = VW'(qou_pkg::atan_turn(ci));
      sq_t    = sq_r_ff + sq_bit_ff;
      rem_sh  = {rem_ff[qou_pkg::REM_W-2:0], num_ff[DW-1]};
      mag     = q_ff[cmd.idx[1:0]][VW-1] ? VW'(-q_ff[cmd.idx[1:0]])
                                         : VW'(q_ff[cmd.idx[1:0]]);
      c_st    = flip_ff ? -cx_ff : cx_ff;
      s_st    = flip_ff ? -cy_ff : cy_ff;
      if ((cmd.idx[1:0] == qou_pkg::SRC_PITCH) ||
          (cmd.idx[1:0] == qou_pkg::SRC_ANGLE && item_ff.mode == qou_pkg::MODE_LOCAL &&
           item_ff.axis == qou_pkg::AXIS_Y)) begin
         s_st = -s_st;
      end
   end

   // cx_ff, cy_ff, cz_ff hold the cordic x, y and z
   always_ff @(posedge clock) begin
      case (cmd.op)
         qou_pkg::OP_LOAD: begin
            item_ff <= req_data;
            n2_ff   <= '0;
         end
         qou_pkg::OP_KEEP: begin
            for (int i = 0; i < 4; i++) begin
               res_ff[i] <= orient_ff[i];
            end
         end
         qou_pkg::OP_CS_INIT: begin
            cx_ff   <= qou_pkg::KINV_Q30;
            cy_ff   <= '0;
            cz_ff   <= VW'($signed(ht_adj));
            flip_ff <= ht_flip;
         end
         qou_pkg::OP_CS_STEP: begin
            if (!cz_ff[VW-1]) begin
               cx_ff <= cx_ff - (cy_ff >>> ci);
               cy_ff <= cy_ff + (cx_ff >>> ci);
               cz_ff <= cz_ff - zinc;
            end else begin
               cx_ff <= cx_ff + (cy_ff >>> ci);
               cy_ff <= cy_ff - (cx_ff >>> ci);
               cz_ff <= cz_ff + zinc;
            end
         end
         qou_pkg::OP_CS_STORE: begin
            c_ff[cmd.idx[1:0]] <= c_st;
            s_ff[cmd.idx[1:0]] <= s_st;
         end
         qou_pkg::OP_EUL_MUL, qou_pkg::OP_ROT_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         qou_pkg::OP_EUL_ACC: begin
            case (cmd.idx[3:0])
               4'd0, 4'd1, 4'd2, 4'd3: t_ff[cmd.idx[1:0]] <= r30;
               4'd4:  q_ff[0] <= r30;
               4'd5:  q_ff[0] <= q_ff[0] + r30;
               4'd6:  q_ff[1] <= r30;
               4'd7:  q_ff[1] <= q_ff[1] - r30;
               4'd8:  q_ff[2] <= r30;
               4'd9:  q_ff[2] <= q_ff[2] + r30;
               4'd10: q_ff[3] <= r30;
               4'd11: q_ff[3] <= q_ff[3] - r30;
               default: n2_ff <= n2_ff + (prod_ff[qou_pkg::N2_W-1:0] >> 2);
            endcase
         end
         qou_pkg::OP_SQRT_INIT: begin
            sq_n_ff   <= n2_ff;
            sq_r_ff   <= '0;
            sq_bit_ff <= qou_pkg::N2_W'(1) << (qou_pkg::N2_W - 2);
         end
         qou_pkg::OP_SQRT_STEP: begin
            if (sq_n_ff >= sq_t) begin
               sq_n_ff <= sq_n_ff - sq_t;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         qou_pkg::OP_IDENT: begin
            res_ff[0] <= qou_pkg::ONE_FIXED;
            res_ff[1] <= '0;
            res_ff[2] <= '0;
            res_ff[3] <= '0;
         end
         qou_pkg::OP_DIV_INIT: begin
            num_ff <= (DW'(mag) << (qou_pkg::FRAC_BITS - 1)) + DW'(len >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            neg_ff <= q_ff[cmd.idx[1:0]][VW-1];
         end
         qou_pkg::OP_DIV_STEP: begin
            if (rem_sh >= qou_pkg::REM_W'(len)) begin
               rem_ff <= rem_sh - qou_pkg::REM_W'(len);
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            num_ff <= num_ff << 1;
         end
         qou_pkg::OP_DIV_STORE: begin
            if (neg_ff) begin
               res_ff[cmd.idx[1:0]] <= (quo_ff > DW'(32768)) ? 16'sh8000 : -quo_ff[15:0];
            end else begin
               res_ff[cmd.idx[1:0]] <= (quo_ff > DW'(32767)) ? 16'sh7fff : quo_ff[15:0];
            end
         end
         qou_pkg::OP_ROT_ACC: begin
            acc_ff <= (j_sel == 2'd0) ? term : (acc_ff + term);
         end
         qou_pkg::OP_ROT_RND: begin
            res_ff[k_sel] <= qou_pkg::sat16(rot_full);
         end
         qou_pkg::OP_COMMIT: begin
            rsp_ff.out_w <= res_ff[0];
            rsp_ff.out_x <= res_ff[1];
            rsp_ff.out_y <= res_ff[2];
            rsp_ff.out_z <= res_ff[3];
         end
         default: begin
         end
      endcase
   end

   // stored orientation and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff[0] <= qou_pkg::ONE_FIXED;
         orient_ff[1] <= '0;
         orient_ff[2] <= '0;
         orient_ff[3] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == qou_pkg::OP_COMMIT) begin
            for (int i = 0; i < 4; i++) begin
               orient_ff[i] <= res_ff[i];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.mode     = item_ff.mode;
   assign sts.axis_bad = (item_ff.axis == qou_pkg::AXIS_NONE);
   assign sts.len_zero = (sq_r_ff == '0);
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

@@ sv/quaternion_orientation_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_orientation_unit
// Orientation quaternion kept in Q2.14, set from euler angles or rotated about
// a principal axis; every transaction returns the new quaternion.
// ----------------------------------------------------------------------------
// One transaction is worked at a time by a sequencer driving a shared datapath.
// A rotation (modes 1 and 2) takes one 16-step cordic pass, then sixteen
// multiply-accumulate pairs and four rounding steps on the single multiplier.
// Setting from euler angles takes three cordic passes, multiply-accumulate
// pairs for the products and the squared length, a 32-step square root and
// four 48-step restoring divisions (skipped for the identity quaternion when
// the length comes out zero). An unused mode or axis returns the stored
// quaternion unchanged. A result that finds the output register still occupied
// waits until it is taken. A new request is taken once the previous result has
// entered the output register.
module quaternion_orientation_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qou_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qou_pkg::rsp_type rsp_data
);

   qou_pkg::cmd_type cmd;
   qou_pkg::sts_type sts;

   qou_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qou_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
